FILE: rtl/dvr_pkg.sv
package dvr_pkg;

    localparam int NODES     = 4;
    localparam int COST_W    = 14;
    localparam int ID_W      = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [COST_W-1:0]             cost_t;
    typedef logic [ID_W-1:0]               node_id_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic [NODES-1:0][COST_W-1:0]  cost_vec_t;

    localparam cfg_idx_t REG_OWN_ID     = 3'd0;
    localparam cfg_idx_t REG_LINK_FIRST = 3'd1;
    localparam cfg_idx_t REG_LINK_LAST  = cfg_idx_t'(NODES);

    localparam node_id_t OWN_ID_RESET = 2'd1;

    localparam logic KIND_INIT   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic     load_init;
        logic     load_update;
        node_id_t src;
    } lane_ctl_t;

    typedef struct packed {
        logic load_init;
        logic load_update;
    } merge_ctl_t;

    function automatic cost_t clamp_cost(cost_t v, cost_t inf);
        return (v > inf) ? inf : v;
    endfunction

endpackage

FILE: rtl/dvr_lane.sv
module dvr_lane #(
    parameter dvr_pkg::cost_t   INF_COST = 14'd9999,
    parameter dvr_pkg::node_id_t LANE    = 2'd0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dvr_pkg::lane_ctl_t  ctl,
    input  dvr_pkg::cost_vec_t  link,
    input  dvr_pkg::cost_t      base,
    input  dvr_pkg::cost_t      recv,
    output dvr_pkg::cost_t      diag,
    output dvr_pkg::cost_t      row_min
);
    import dvr_pkg::*;

    cost_vec_t         row_reg;
    cost_vec_t         row_next;
    cost_t             min_reg;
    cost_t             min_next;
    logic [COST_W:0]   sum;
    cost_t             upd_val;
    cost_t             m01;
    cost_t             m23;

    // saturating link base + received cost
    always_comb
    begin
        sum     = {1'b0, base} + {1'b0, clamp_cost(recv, INF_COST)};
        upd_val = (sum > {1'b0, INF_COST}) ? INF_COST : sum[COST_W-1:0];
    end

    always_comb
    begin
        row_next = row_reg;
        if (ctl.load_init)
        begin
            for (int j = 0; j < NODES; j++)
            begin
                row_next[j] = (node_id_t'(j) == LANE) ? clamp_cost(link[j], INF_COST)
                                                      : INF_COST;
            end
        end
        else if (ctl.load_update)
        begin
            row_next[ctl.src] = upd_val;
        end
    end

    always_comb
    begin
        m01      = (row_reg[1] < row_reg[0]) ? row_reg[1] : row_reg[0];
        m23      = (row_reg[3] < row_reg[2]) ? row_reg[3] : row_reg[2];
        min_next = (m23 < m01) ? m23 : m01;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= {NODES{INF_COST}};
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
    end

    assign diag    = row_reg[LANE];
    assign row_min = min_reg;

endmodule

FILE: rtl/dvr_merge.sv
module dvr_merge #(
    parameter dvr_pkg::cost_t INF_COST = 14'd9999
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dvr_pkg::merge_ctl_t ctl,
    input  dvr_pkg::node_id_t   own_id,
    input  dvr_pkg::cost_vec_t  link,
    input  dvr_pkg::cost_vec_t  mins,
    output dvr_pkg::cost_vec_t  best,
    output logic                changed
);
    import dvr_pkg::*;

    cost_vec_t best_reg;
    cost_vec_t best_next;

    always_comb
    begin
        best_next = best_reg;
        if (ctl.load_init)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                best_next[i] = (node_id_t'(i) == own_id) ? '0 : clamp_cost(link[i], INF_COST);
            end
        end
        else if (ctl.load_update)
        begin
            best_next = mins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= {NODES{INF_COST}};
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best    = best_reg;
    assign changed = (mins != best_reg);

endmodule

FILE: rtl/distance_vector_route_update.sv
// Distance-vector routing node for a four-node network. Each row of the distance
// table lives in its own lane; the lanes apply an init or a received vector in the
// accept cycle, register their row minima the next cycle, and a merge stage then
// updates the own vector and detects a change. A sequencer scans the node slots,
// one per cycle while no neighbor slot waits on a stalled output, from slot 0 up
// to the last neighbor, and sends one packet per neighbor in increasing id order,
// last set on the final one. An update that leaves the own vector unchanged goes
// back to idle after the merge; any other item scans one to four slots, even with
// no neighbor. The output register lets the next item be accepted while the final
// packet still waits.
module distance_vector_route_update #(
    parameter dvr_pkg::cost_t INF_COST = 14'd9999
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  dvr_pkg::cfg_idx_t    cfg_index,
    input  dvr_pkg::cost_t       cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  dvr_pkg::node_id_t    sender_id,
    input  dvr_pkg::cost_t       recv_cost_0,
    input  dvr_pkg::cost_t       recv_cost_1,
    input  dvr_pkg::cost_t       recv_cost_2,
    input  dvr_pkg::cost_t       recv_cost_3,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dvr_pkg::node_id_t    dest_id,
    output dvr_pkg::cost_t       vec_cost_0,
    output dvr_pkg::cost_t       vec_cost_1,
    output dvr_pkg::cost_t       vec_cost_2,
    output dvr_pkg::cost_t       vec_cost_3,
    output logic                 last
);
    import dvr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MIN   = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_SEND  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    node_id_t          idx_reg;
    node_id_t          idx_next;
    logic              kind_reg;
    node_id_t          own_id_reg;
    cost_vec_t         link_reg;
    cost_t             link_slot;

    logic              out_valid_reg;
    logic              out_valid_next;
    node_id_t          dest_reg;
    cost_vec_t         vec_reg;
    logic              last_reg;

    logic              in_accept;
    logic              cfg_accept;
    cost_vec_t         recv_vec;
    cost_vec_t         diag_vec;
    cost_vec_t         min_vec;
    cost_vec_t         best_vec;
    cost_t             base;
    logic              changed;
    lane_ctl_t         lane_ctl;
    merge_ctl_t        merge_ctl;

    logic [NODES-1:0]  nbr_mask;
    logic              later_nbr;
    logic              slot_free;
    logic              out_load;
    logic              advance;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;

    assign recv_vec = {recv_cost_3, recv_cost_2, recv_cost_1, recv_cost_0};
    assign base     = diag_vec[sender_id];

    assign lane_ctl.load_init   = in_accept && (kind == KIND_INIT);
    assign lane_ctl.load_update = in_accept && (kind == KIND_UPDATE);
    assign lane_ctl.src         = sender_id;

    assign merge_ctl.load_init   = (state_reg == S_MERGE) && (kind_reg == KIND_INIT);
    assign merge_ctl.load_update = (state_reg == S_MERGE) && (kind_reg == KIND_UPDATE);

    for (genvar g = 0; g < NODES; g++)
    begin : g_lane
        dvr_lane #(
            .INF_COST (INF_COST),
            .LANE     (node_id_t'(g))
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (lane_ctl),
            .link    (link_reg),
            .base    (base),
            .recv    (recv_vec[g]),
            .diag    (diag_vec[g]),
            .row_min (min_vec[g])
        );
    end

    dvr_merge #(
        .INF_COST (INF_COST)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (merge_ctl),
        .own_id  (own_id_reg),
        .link    (link_reg),
        .mins    (min_vec),
        .best    (best_vec),
        .changed (changed)
    );

    // config registers
    assign link_slot = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= OWN_ID_RESET;
            link_reg   <= {NODES{INF_COST}};
        end
        else if (cfg_accept)
        begin
            if (cfg_index == REG_OWN_ID)
            begin
                own_id_reg <= cfg_data[ID_W-1:0];
            end
            else if (cfg_index >= REG_LINK_FIRST && cfg_index <= REG_LINK_LAST)
            begin
                link_reg[ID_W'(cfg_index - REG_LINK_FIRST)] <= link_slot;
            end
        end
    end

    // neighbor scan
    always_comb
    begin
        later_nbr = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            nbr_mask[i] = (node_id_t'(i) != own_id_reg) && (link_reg[i] < INF_COST);
        end
        for (int i = 0; i < NODES; i++)
        begin
            if (nbr_mask[i] && (node_id_t'(i) > idx_reg))
            begin
                later_nbr = 1'b1;
            end
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_SEND) && nbr_mask[idx_reg] && slot_free;
    assign advance   = (state_reg == S_SEND) && (!nbr_mask[idx_reg] || slot_free);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                idx_next = '0;
                if (kind_reg == KIND_INIT || changed)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEND:
            begin
                if (advance)
                begin
                    if (!later_nbr)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= kind;
        end
        if (out_load)
        begin
            dest_reg <= idx_reg;
            vec_reg  <= best_vec;
            last_reg <= !later_nbr;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_id    = dest_reg;
    assign vec_cost_0 = vec_reg[0];
    assign vec_cost_1 = vec_reg[1];
    assign vec_cost_2 = vec_reg[2];
    assign vec_cost_3 = vec_reg[3];
    assign last       = last_reg;

    // own vector never exceeds infinity
    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        best_vec[0] <= INF_COST && best_vec[1] <= INF_COST &&
        best_vec[2] <= INF_COST && best_vec[3] <= INF_COST)
        else $error("own vector entry above infinity");

    // final packet ends the announcement
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !later_nbr |=> state_reg == S_IDLE)
        else $error("sequencer still sending after final packet");

    // init zeroes the node's own entry
    a_init_own_zero: assert property (@(posedge clk) disable iff (!rst_n)
        merge_ctl.load_init |=> best_vec[own_id_reg] == '0)
        else $error("own entry not zero after init");

    // packets only go to neighbors
    a_dest_nbr: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> nbr_mask[idx_reg] && idx_reg != own_id_reg)
        else $error("packet addressed to a non-neighbor");

endmodule

FILE: tb/distance_vector_route_update_test.sv
`timescale 1ns / 1ps

module distance_vector_route_update_test;
    import dvr_pkg::*;

    localparam cost_t    INF         = 14'd9999;
    localparam cost_t    NIL         = 14'd0;
    localparam cost_t    CMAX        = 14'h3FFF;
    localparam int       LIMIT       = 200000;
    localparam int       HOLD_CYCLES = 300;
    localparam int       RAND_PHASES = 6;
    localparam int       PHASE_ITEMS = 48;
    localparam int       SETTLE      = 12;
    localparam cfg_idx_t REG_UNUSED  = 3'd7;

    typedef struct {
        logic      kind;
        node_id_t  sender;
        cost_vec_t recv;
    } route_msg_t;

    typedef struct {
        node_id_t  dest;
        cost_vec_t vec;
        logic      last;
    } route_pkt_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       kind;
        node_id_t   sender;
        cost_t      c0, c1, c2, c3;
        logic       typed;
        logic [3:0] dests;
        cost_t      v0, v1, v2, v3;
    } dir_row_t;

    typedef struct packed {
        node_id_t own;
        cost_t    l0, l1, l2, l3;
    } dir_cfg_t;

    // phase 0 runs on reset values, no writes
    localparam dir_cfg_t DIR_CFG [3] = '{
        '{OWN_ID_RESET, INF, INF, INF, INF},
        '{2'd0, 14'd7, NIL, CMAX, 14'd9998},
        '{2'd3, NIL, NIL, NIL, NIL}
    };

    localparam dir_row_t DIR_ROWS [18] = '{
        '{2'd0, KIND_UPDATE, 2'd0, NIL, NIL, NIL, NIL, 1'b1, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd0, KIND_INIT, 2'd1, CMAX, CMAX, CMAX, CMAX, 1'b1, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd0, KIND_UPDATE, 2'd1, NIL, NIL, NIL, NIL, 1'b1, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_INIT, 2'd0, NIL, NIL, NIL, NIL, 1'b1, 4'b1010, NIL, NIL, INF, 14'd9998},
        '{2'd1, KIND_UPDATE, 2'd1, NIL, NIL, NIL, NIL, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_UPDATE, 2'd1, NIL, NIL, NIL, NIL, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_UPDATE, 2'd3, CMAX, CMAX, CMAX, CMAX, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_UPDATE, 2'd2, 14'd1, 14'd2, 14'd3, 14'd4, 1'b0, 4'b0000,
          NIL, NIL, NIL, NIL},
        '{2'd1, KIND_UPDATE, 2'd0, 14'd5, NIL, INF, 14'd1, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_UPDATE, 2'd3, INF, INF, INF, NIL, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_UPDATE, 2'd1, INF, INF, INF, INF, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd1, KIND_INIT, 2'd3, CMAX, NIL, CMAX, NIL, 1'b1, 4'b1010, NIL, NIL, INF, 14'd9998},
        '{2'd2, KIND_INIT, 2'd0, NIL, NIL, NIL, NIL, 1'b1, 4'b0111, NIL, NIL, NIL, NIL},
        '{2'd2, KIND_UPDATE, 2'd0, CMAX, CMAX, CMAX, CMAX, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd2, KIND_UPDATE, 2'd2, NIL, NIL, NIL, NIL, 1'b0, 4'b0000, NIL, NIL, NIL, NIL},
        '{2'd2, KIND_UPDATE, 2'd3, 14'd1, 14'd1, 14'd1, 14'd1, 1'b0, 4'b0000,
          NIL, NIL, NIL, NIL},
        '{2'd2, KIND_UPDATE, 2'd1, 14'd9998, INF, 14'd10000, NIL, 1'b0, 4'b0000,
          NIL, NIL, NIL, NIL},
        '{2'd2, KIND_UPDATE, 2'd0, 14'd3, 14'd2, 14'd1, NIL, 1'b0, 4'b0000, NIL, NIL, NIL, NIL}
    };

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cost_t     cfg_data;
    logic      in_valid;
    logic      in_stall;
    logic      kind;
    node_id_t  sender_id;
    cost_t     recv_cost_0;
    cost_t     recv_cost_1;
    cost_t     recv_cost_2;
    cost_t     recv_cost_3;
    logic      out_valid;
    logic      out_stall;
    node_id_t  dest_id;
    cost_t     vec_cost_0;
    cost_t     vec_cost_1;
    cost_t     vec_cost_2;
    cost_t     vec_cost_3;
    logic      last;

    int        errors = 0;
    int        cycles = 0;
    logic      quiet = 1'b0;
    logic      long_hold = 1'b0;
    logic      hold_done = 1'b0;

    node_id_t   self_id;
    cost_t      link_cfg [NODES];
    cost_t      dtab [NODES*NODES];
    cost_t      best_cost [NODES];
    route_pkt_t pending_pkts [$];

    distance_vector_route_update DUT (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cost_t sat_cost(int unsigned v);
        return (v > INF) ? INF : cost_t'(v);
    endfunction

    function automatic logic is_link(int i);
        return (i != self_id) && (sat_cost(link_cfg[i]) < INF);
    endfunction

    function automatic void emit_vector(ref route_pkt_t pk [$]);
        route_pkt_t p;
        for (int i = 0; i < NODES; i++) begin
            if (is_link(i)) begin
                p.dest = node_id_t'(i);
                for (int j = 0; j < NODES; j++)
                    p.vec[j] = best_cost[j];
                p.last = 1'b0;
                pk.push_back(p);
            end
        end
        if (pk.size() > 0)
            pk[pk.size()-1].last = 1'b1;
    endfunction

    function automatic void route_step(input route_msg_t m, ref route_pkt_t pk [$]);
        cost_t base;
        cost_t row_min;
        logic  changed;
        if (m.kind == KIND_INIT) begin
            for (int i = 0; i < NODES; i++) begin
                for (int j = 0; j < NODES; j++)
                    dtab[i*NODES+j] = (i == j) ? sat_cost(link_cfg[j]) : INF;
                best_cost[i] = (i == self_id) ? NIL : sat_cost(link_cfg[i]);
            end
            emit_vector(pk);
        end
        else begin
            base = dtab[int'(m.sender)*NODES + int'(m.sender)];
            for (int i = 0; i < NODES; i++)
                dtab[i*NODES + int'(m.sender)] =
                    sat_cost(32'(base) + 32'(sat_cost(m.recv[i])));
            changed = 1'b0;
            for (int i = 0; i < NODES; i++) begin
                row_min = dtab[i*NODES];
                for (int j = 1; j < NODES; j++)
                    if (dtab[i*NODES+j] < row_min)
                        row_min = dtab[i*NODES+j];
                if (row_min != best_cost[i])
                    changed = 1'b1;
                best_cost[i] = row_min;
            end
            if (changed)
                emit_vector(pk);
        end
    endfunction

    function automatic void apply_cfg(cfg_idx_t idx, cost_t data);
        if (idx == REG_OWN_ID)
            self_id = data[ID_W-1:0];
        else if (idx >= REG_LINK_FIRST && idx <= REG_LINK_LAST)
            link_cfg[idx - REG_LINK_FIRST] = data;
    endfunction

    function automatic cost_t rand_cost();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return cost_t'($urandom_range(0, 60));
        if (r < 15)
            return INF;
        if (r < 17)
            return cost_t'($urandom_range(10000, 16383));
        return cost_t'($urandom());
    endfunction

    function automatic cost_t rand_link();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return cost_t'($urandom_range(1, 40));
        if (r == 6)
            return NIL;
        if (r == 7)
            return INF;
        if (r == 8)
            return cost_t'($urandom_range(10000, 16383));
        return cost_t'($urandom());
    endfunction

    task automatic cfg_write(input cfg_idx_t idx, input cost_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_cfg(idx, data);
    endtask

    task automatic cfg_node(input node_id_t own, input cost_vec_t links);
        cfg_write(REG_OWN_ID, cost_t'(own));
        for (int i = 0; i < NODES; i++)
            cfg_write(REG_LINK_FIRST + cfg_idx_t'(i), links[i]);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pkts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_item(input route_msg_t m, input logic typed, input logic [3:0] dests,
                             input cost_vec_t vec);
        route_pkt_t pk [$];
        route_pkt_t p;
        in_valid    <= 1'b1;
        kind        <= m.kind;
        sender_id   <= m.sender;
        recv_cost_0 <= m.recv[0];
        recv_cost_1 <= m.recv[1];
        recv_cost_2 <= m.recv[2];
        recv_cost_3 <= m.recv[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        route_step(m, pk);
        if (typed) begin
            pk.delete();
            for (int i = 0; i < NODES; i++) begin
                if (dests[i]) begin
                    p.dest = node_id_t'(i);
                    p.vec  = vec;
                    p.last = 1'b0;
                    pk.push_back(p);
                end
            end
            if (pk.size() > 0)
                pk[pk.size()-1].last = 1'b1;
        end
        foreach (pk[i])
            pending_pkts.push_back(pk[i]);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // receiver: random stall bursts, one long hold-off to back the block up
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        route_pkt_t want;
        cost_vec_t  got;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pkts.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual dest_id %0d",
                         $time, dest_id);
            end
            else begin
                want = pending_pkts.pop_front();
                got  = {vec_cost_3, vec_cost_2, vec_cost_1, vec_cost_0};
                if (dest_id !== want.dest) begin
                    errors++;
                    $display("%0t: dest_id expected %0d actual %0d", $time, want.dest, dest_id);
                end
                for (int j = 0; j < NODES; j++) begin
                    if (got[j] !== want.vec[j]) begin
                        errors++;
                        $display("%0t: vec_cost_%0d expected %0d actual %0d",
                                 $time, j, want.vec[j], got[j]);
                    end
                end
                if (last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("FAIL distance_vector_route_update");
            $finish;
        end
    end

    initial begin
        route_msg_t m;
        dir_row_t   row;
        cost_vec_t  links;
        cost_vec_t  vec;
        logic [1:0] cur_phase;
        node_id_t   nbrs [$];

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_OWN_ID;
        cfg_data    = NIL;
        in_valid    = 1'b0;
        kind        = KIND_INIT;
        sender_id   = '0;
        recv_cost_0 = NIL;
        recv_cost_1 = NIL;
        recv_cost_2 = NIL;
        recv_cost_3 = NIL;

        self_id = OWN_ID_RESET;
        for (int i = 0; i < NODES; i++) begin
            link_cfg[i]  = INF;
            best_cost[i] = INF;
        end
        for (int i = 0; i < NODES*NODES; i++)
            dtab[i] = INF;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_phase = 2'd0;
        foreach (DIR_ROWS[k]) begin
            row = DIR_ROWS[k];
            if (row.phase != cur_phase) begin
                wait_idle();
                cur_phase = row.phase;
                links = {DIR_CFG[cur_phase].l3, DIR_CFG[cur_phase].l2,
                         DIR_CFG[cur_phase].l1, DIR_CFG[cur_phase].l0};
                cfg_node(DIR_CFG[cur_phase].own, links);
            end
            m.kind   = row.kind;
            m.sender = row.sender;
            m.recv   = {row.c3, row.c2, row.c1, row.c0};
            vec      = {row.v3, row.v2, row.v1, row.v0};
            push_item(m, row.typed, row.dests, vec);
            sender_gap();
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            for (int i = 0; i < NODES; i++)
                links[i] = rand_link();
            if (ph == 0)
                cfg_write(REG_UNUSED, cost_t'($urandom()));
            cfg_node((ph == 0) ? node_id_t'(2) : node_id_t'($urandom_range(0, 3)), links);
            if (ph == 1)
                long_hold = 1'b1;
            if (ph == RAND_PHASES - 1)
                quiet = 1'b1;
            nbrs.delete();
            for (int i = 0; i < NODES; i++)
                if (is_link(i))
                    nbrs.push_back(node_id_t'(i));

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // phase 3 does not force an init first, so updates may land on a stale table
                if ((k == 0 && ph != 3) || $urandom_range(0, 11) == 0)
                    m.kind = KIND_INIT;
                else
                    m.kind = KIND_UPDATE;
                for (int j = 0; j < NODES; j++)
                    m.recv[j] = rand_cost();
                if (nbrs.size() > 0 && $urandom_range(0, 4) != 0) begin
                    m.sender = nbrs[$urandom_range(0, nbrs.size() - 1)];
                    if ($urandom_range(0, 4) != 0)
                        m.recv[m.sender] = NIL;
                end
                else
                    m.sender = node_id_t'($urandom_range(0, 3));
                push_item(m, 1'b0, 4'b0000, '0);
                sender_gap();
            end
        end

        in_valid <= 1'b0;
        while (pending_pkts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS distance_vector_route_update");
        else
            $display("FAIL distance_vector_route_update");
        $finish;
    end

endmodule

FILE: files.f
rtl/dvr_pkg.sv
rtl/dvr_lane.sv
rtl/dvr_merge.sv
rtl/distance_vector_route_update.sv
tb/distance_vector_route_update_test.sv
